// File: sv/hbc_pkg.sv
// ----------------------------------------------------------------------------
// Histogram binning counter package
// Shared widths, function codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package hbc_pkg;

  // Default values of the top-level parameters.
  localparam int MAX_BINS_DEF   = 64;
  localparam int COUNT_BITS_DEF = 32;

  // Fixed field widths.
  localparam int DATA_W      = 32;
  localparam int BIN_FIELD_W = 7;
  localparam int FUNC_W      = 2;
  localparam int CFG_INDEX_W = 2;

  // Function codes carried by an input item.
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_MINIMUM = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_MAXIMUM = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REGULAR_BINS  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BIN_WIDTH     = 2'd3;

  // Configuration reset values.
  localparam logic signed [DATA_W-1:0] RANGE_MINIMUM_RST = 32'sd0;
  localparam logic signed [DATA_W-1:0] RANGE_MAXIMUM_RST = 32'sd64;
  localparam logic [BIN_FIELD_W-1:0]   REGULAR_BINS_RST  = 7'd64;
  localparam logic [DATA_W-1:0]        BIN_WIDTH_RST     = 32'd1;

endpackage

// File: sv/hbc_if.sv
// ----------------------------------------------------------------------------
// Histogram binning counter channels
// Valid/ready channels for the request items and the result items.
// ----------------------------------------------------------------------------
interface hbc_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [hbc_pkg::FUNC_W-1:0]             func;
  logic signed [hbc_pkg::DATA_W-1:0]      sample_value;
  logic [hbc_pkg::BIN_FIELD_W-1:0]        read_bin;

  modport source (output valid, func, sample_value, read_bin, input ready);
  modport sink   (input valid, func, sample_value, read_bin, output ready);
endinterface

interface hbc_out_if;
  logic                              valid;
  logic                              ready;
  logic [hbc_pkg::BIN_FIELD_W-1:0]   bin_selected;
  logic [hbc_pkg::DATA_W-1:0]        bin_count;
  logic [hbc_pkg::DATA_W-1:0]        total_count;

  modport source (output valid, bin_selected, bin_count, total_count, input ready);
  modport sink   (input valid, bin_selected, bin_count, total_count, output ready);
endinterface

// File: sv/histogram_binning_counter.sv
// Insert inside the range: the 32-step divider finds the bin index, then the bin
// RAM is read and updated. Insert outside the range reads and updates the bin RAM;
// read only reads it. Clear, unused code and read beyond the overflow bin skip the
// RAM. A new item is taken only once the last result is in the output register.
// Synchronous reset restores the registers and empties every bin at once through
// per-bin valid flags; clear empties the bins and the total the same way.
// ----------------------------------------------------------------------------
// Histogram binning counter
// Underflow, equal-width and overflow bins with saturating counts and total.
// ----------------------------------------------------------------------------
module histogram_binning_counter #(
  parameter int MAX_BINS   = hbc_pkg::MAX_BINS_DEF,
  parameter int COUNT_BITS = hbc_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [hbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hbc_pkg::DATA_W-1:0]      cfg_data,
  hbc_in_if.sink                          sample_ch,
  hbc_out_if.source                       result_ch
);

  localparam int SLOTS  = MAX_BINS + 2;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int DW     = hbc_pkg::DATA_W;
  localparam int BW     = hbc_pkg::BIN_FIELD_W;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CLASS = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_RD    = 6'b001000,
    ST_UPD   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state;

  logic signed [DW-1:0] range_minimum;
  logic signed [DW-1:0] range_maximum;
  logic [BW-1:0]        regular_bins;
  logic [DW-1:0]        bin_width;

  logic [hbc_pkg::FUNC_W-1:0] op_func;
  logic signed [DW-1:0]       op_sample;
  logic [BW-1:0]              op_rbin;

  logic [ADDR_W-1:0]     addr;
  logic [BW-1:0]         res_sel;
  logic [DW-1:0]         res_cnt;
  logic [COUNT_BITS-1:0] total;
  logic [SLOTS-1:0]      valid;

  logic          out_valid;
  logic [BW-1:0] out_sel;
  logic [DW-1:0] out_cnt;
  logic [DW-1:0] out_total;

  logic [ADDR_W-1:0]     nb;
  logic [DW-1:0]         diff;
  logic [DW-1:0]         divisor;
  logic                  div_start;
  logic                  div_done;
  logic [DW-1:0]         quotient;
  logic [ADDR_W-1:0]     sel_q;
  logic                  below_min;
  logic                  at_max;
  logic                  rbin_ok;
  logic                  ram_we;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] inc;

  // Bins in use: zero acts as one, anything above the storage acts as the storage.
  always_comb begin
    if (regular_bins == '0) begin
      nb = ADDR_W'(1);
    end else if (32'(regular_bins) > 32'(MAX_BINS)) begin
      nb = ADDR_W'(MAX_BINS);
    end else begin
      nb = ADDR_W'(regular_bins);
    end
  end

  assign below_min = op_sample < range_minimum;
  assign at_max    = op_sample >= range_maximum;
  assign diff      = op_sample - range_minimum;
  assign divisor   = (bin_width == '0) ? DW'(1) : bin_width;
  assign rbin_ok   = 32'(op_rbin) <= 32'(nb) + 32'd1;
  assign div_start = (state == ST_CLASS) && (op_func == hbc_pkg::FUNC_INSERT) &&
                     !below_min && !at_max;
  assign sel_q     = (quotient >= 32'(nb)) ? nb : ADDR_W'(quotient + 32'd1);

  // A bin whose valid flag is clear has not been written since the last clear.
  assign cur    = valid[addr] ? ram_rdata : '0;
  assign inc    = (cur == '1) ? cur : cur + 1'b1;
  assign ram_we = (state == ST_UPD) && (op_func == hbc_pkg::FUNC_INSERT);

  hbc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  hbc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (inc),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      valid         <= '0;
      total         <= '0;
      range_minimum <= hbc_pkg::RANGE_MINIMUM_RST;
      range_maximum <= hbc_pkg::RANGE_MAXIMUM_RST;
      regular_bins  <= hbc_pkg::REGULAR_BINS_RST;
      bin_width     <= hbc_pkg::BIN_WIDTH_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hbc_pkg::REG_RANGE_MINIMUM: range_minimum <= cfg_data;
          hbc_pkg::REG_RANGE_MAXIMUM: range_maximum <= cfg_data;
          hbc_pkg::REG_REGULAR_BINS:  regular_bins  <= cfg_data[BW-1:0];
          hbc_pkg::REG_BIN_WIDTH:     bin_width     <= cfg_data;
          default: ;
        endcase
      end

      // The output register takes a new item when it is empty or being drained.
      if ((state == ST_DONE) && (!out_valid || result_ch.ready)) begin
        out_valid <= 1'b1;
        out_sel   <= res_sel;
        out_cnt   <= res_cnt;
        out_total <= DW'(total);
      end else if (out_valid && result_ch.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (sample_ch.valid) begin
            op_func   <= sample_ch.func;
            op_sample <= sample_ch.sample_value;
            op_rbin   <= sample_ch.read_bin;
            state     <= ST_CLASS;
          end
        end
        ST_CLASS: begin
          case (op_func)
            hbc_pkg::FUNC_INSERT: begin
              if (below_min) begin
                addr    <= '0;
                res_sel <= '0;
                state   <= ST_RD;
              end else if (at_max) begin
                addr    <= nb + ADDR_W'(1);
                res_sel <= BW'(nb + ADDR_W'(1));
                state   <= ST_RD;
              end else begin
                state <= ST_DIV;
              end
            end
            hbc_pkg::FUNC_READ: begin
              res_sel <= op_rbin;
              if (rbin_ok) begin
                addr  <= ADDR_W'(op_rbin);
                state <= ST_RD;
              end else begin
                res_cnt <= '0;
                state   <= ST_DONE;
              end
            end
            hbc_pkg::FUNC_CLEAR: begin
              valid   <= '0;
              total   <= '0;
              res_sel <= '0;
              res_cnt <= '0;
              state   <= ST_DONE;
            end
            default: begin
              res_sel <= '0;
              res_cnt <= '0;
              state   <= ST_DONE;
            end
          endcase
        end
        ST_DIV: begin
          if (div_done) begin
            addr    <= sel_q;
            res_sel <= BW'(sel_q);
            state   <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (op_func == hbc_pkg::FUNC_INSERT) begin
            valid[addr] <= 1'b1;
            total       <= (total == '1) ? total : total + 1'b1;
            res_cnt     <= DW'(inc);
          end else begin
            res_cnt <= DW'(cur);
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || result_ch.ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign sample_ch.ready        = (state == ST_IDLE);
  assign result_ch.valid        = out_valid;
  assign result_ch.bin_selected = out_sel;
  assign result_ch.bin_count    = out_cnt;
  assign result_ch.total_count  = out_total;

endmodule

// File: sv/hbc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 66
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/hbc_div.sv
// ----------------------------------------------------------------------------
// Histogram binning divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hbc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [hbc_pkg::DATA_W-1:0] dividend,
  input  logic [hbc_pkg::DATA_W-1:0] divisor,
  output logic                       done,
  output logic [hbc_pkg::DATA_W-1:0] quotient
);

  localparam int W     = hbc_pkg::DATA_W;
  localparam int CNT_W = $clog2(W);

  logic [W-1:0]     rem;
  logic [W-1:0]     dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [W:0]       rem_shift;
  logic [W:0]       trial;

  // Bring down the next dividend bit and try a subtraction.
  assign rem_shift = {rem, quotient[W-1]};
  assign trial     = rem_shift - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= '0;
        quotient <= dividend;
        dsr      <= divisor;
        cnt      <= CNT_W'(W - 1);
        busy     <= 1'b1;
      end else if (busy) begin
        if (!trial[W]) begin
          rem      <= trial[W-1:0];
          quotient <= {quotient[W-2:0], 1'b1};
        end else begin
          rem      <= rem_shift[W-1:0];
          quotient <= {quotient[W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/hbc_checker.sv
// ----------------------------------------------------------------------------
// Histogram binning counter checker
// Port-level assertions on sequencing and result hand-off.
// ----------------------------------------------------------------------------
module hbc_checker (
  input logic       clk,
  input logic       rst,
  hbc_in_if.sink    sample_ch,
  hbc_out_if.source result_ch
);

  // Only one item is in work, so ready drops right after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sample_ch.valid && sample_ch.ready |=> !sample_ch.ready)
    else $error("input ready stayed high after an accepted item");

  // No result can appear in the cycle right after an item is taken.
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    sample_ch.valid && sample_ch.ready && !result_ch.valid |=> !result_ch.valid)
    else $error("result appeared one cycle after accept");

  // A stalled result holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid && !result_ch.ready |=>
      result_ch.valid && $stable(result_ch.bin_selected) &&
      $stable(result_ch.bin_count) && $stable(result_ch.total_count))
    else $error("stalled result changed or dropped");

  // Reset leaves the block empty and ready.
  a_reset_state: assert property (@(posedge clk)
    rst |=> !result_ch.valid && sample_ch.ready)
    else $error("block not idle after reset");

endmodule

bind histogram_binning_counter hbc_checker u_hbc_checker (
  .clk       (clk),
  .rst       (rst),
  .sample_ch (sample_ch),
  .result_ch (result_ch)
);
